// ----- rtl/trace_buffer_with_run_coalescing_defines.svh -----
// Assertion macros for the trace buffer
`ifndef TRACE_BUFFER_WITH_RUN_COALESCING_DEFINES_SVH
`define TRACE_BUFFER_WITH_RUN_COALESCING_DEFINES_SVH
`define TB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/tbrc_pkg.sv -----
// ----------------------------------------------------------------------------
// tbrc_pkg
// Types and constants shared by the trace buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tbrc_pkg;
	localparam logic [2:0] OP_ARM    = 3'd0;
	localparam logic [2:0] OP_RECORD = 3'd1;
	localparam logic [2:0] OP_STOP   = 3'd2;
	localparam logic [2:0] OP_DISARM = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;
	localparam logic [1:0] REG_SUMMARIZE = 2'd0;
	localparam logic [31:0] STOP_KIND       = 32'd16;
	localparam logic [31:0] PLAIN_STOP_KIND = 32'd6;
	localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
	localparam int CMD_DEPTH = 2;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] kind;
		logic [31:0] addr;
		logic [31:0] size;
		logic [31:0] res;
		logic [7:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic [31:0] kind;
		logic [31:0] addr;
		logic [31:0] size;
		logic [31:0] res;
		logic [8:0]  count;
		logic [31:0] drops;
	} rsp_t;
endpackage

// ----- rtl/tbrc_if.sv -----
// ----------------------------------------------------------------------------
// tbrc_cmd_if / tbrc_rsp_if
// Valid/ready channels for trace commands and read results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface tbrc_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [31:0] event_kind;
	logic [31:0] event_address;
	logic [31:0] event_size;
	logic [31:0] event_result;
	logic [7:0]  read_index;
	modport source (output valid, op, event_kind, event_address, event_size,
		event_result, read_index, input ready);
	modport sink (input valid, op, event_kind, event_address, event_size,
		event_result, read_index, output ready);
endinterface

interface tbrc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] entry_kind;
	logic [31:0] entry_address;
	logic [31:0] entry_size;
	logic [31:0] entry_result;
	logic [8:0]  entry_count;
	logic [31:0] drop_total;
	modport source (output valid, entry_kind, entry_address, entry_size,
		entry_result, entry_count, drop_total, input ready);
	modport sink (input valid, entry_kind, entry_address, entry_size,
		entry_result, entry_count, drop_total, output ready);
endinterface

// ----- rtl/tbrc_front.sv -----
// ----------------------------------------------------------------------------
// tbrc_front
// Accepts command items and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tbrc_front (
	input  logic clk,
	input  logic arst_n,
	tbrc_cmd_if.sink in_ch,
	output logic q_valid,
	output tbrc_pkg::cmd_t q_cmd,
	input  logic q_pop
);
	import tbrc_pkg::*;
	localparam int PW = $clog2(CMD_DEPTH);
	cmd_t fifo_q [CMD_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic push;

	assign in_ch.ready = (cnt_q != CMD_DEPTH[PW:0]);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != '0);
	assign q_cmd = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{op: in_ch.op, kind: in_ch.event_kind,
				addr: in_ch.event_address, size: in_ch.event_size,
				res: in_ch.event_result, idx: in_ch.read_index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{PW{1'b0}}, push} - {{PW{1'b0}}, q_pop};
		end
	end
endmodule

// ----- rtl/tbrc_back.sv -----
// ----------------------------------------------------------------------------
// tbrc_back
// Executes queued commands on the trace store, scanning the tail run for stops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tbrc_back #(
	parameter int TRACE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic summarize,
	input  logic q_valid,
	input  tbrc_pkg::cmd_t q_cmd,
	output logic q_pop,
	output logic rsp_valid,
	output tbrc_pkg::rsp_t rsp,
	input  logic rsp_ready
);
	import tbrc_pkg::*;
	localparam int AW = $clog2(TRACE_DEPTH);
	localparam int CW = AW + 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_CHK  = 6'b000100,
		S_WAIT = 6'b001000,
		S_RDW  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [127:0] mem [TRACE_DEPTH];
	logic [127:0] rd_q;
	logic [AW-1:0] raddr;
	logic rd_en;
	logic we;
	logic [AW-1:0] waddr;
	logic [127:0] wdata;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] scan_q;
	logic [31:0] drop_q;
	logic cap_q;
	cmd_t cmd_q;
	logic [31:0] rk, ra, rs, rr;
	logic full;
	logic [31:0] drop_inc;

	assign {rk, ra, rs, rr} = rd_q;
	assign full = (fill_q >= CW'(TRACE_DEPTH));
	assign drop_inc = (drop_q == ALL_ONES) ? drop_q : drop_q + 32'd1;
	assign q_pop = (state_q == S_IDLE) && q_valid && !rsp_valid;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (rd_en) rd_q <= mem[raddr];
	end

	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		we = 1'b0;
		waddr = fill_q[AW-1:0];
		wdata = '0;
		case (state_q)
			S_RD: begin
				rd_en = 1'b1;
				raddr = AW'(scan_q - CW'(1));
			end
			S_CHK: begin
				if (rk == STOP_KIND && ra == cmd_q.addr && rr == cmd_q.res) begin
					if (rs != ALL_ONES) begin
						we = 1'b1;
						waddr = AW'(scan_q - CW'(1));
						wdata = {rk, ra, rs + 32'd1, rr};
					end
				end else if (rk != STOP_KIND || scan_q == CW'(1)) begin
					we = !full;
					wdata = {STOP_KIND, cmd_q.addr, 32'd1, cmd_q.res};
				end
			end
			S_IDLE: begin
				if (q_pop && cap_q && !full) begin
					if (q_cmd.op == OP_RECORD) begin
						we = 1'b1;
						wdata = {q_cmd.kind, q_cmd.addr, q_cmd.size, q_cmd.res};
					end else if (q_cmd.op == OP_STOP && (!summarize || fill_q == '0))
							begin
						we = 1'b1;
						wdata = {summarize ? STOP_KIND : PLAIN_STOP_KIND,
							q_cmd.addr, summarize ? 32'd1 : 32'd0, q_cmd.res};
					end
				end
				if (q_pop && q_cmd.op == OP_READ) begin
					rd_en = 1'b1;
					raddr = AW'(q_cmd.idx);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			scan_q <= '0;
			drop_q <= '0;
			cap_q <= 1'b0;
			rsp_valid <= 1'b0;
			cmd_q <= '0;
			rsp <= '0;
		end else begin
			if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						cmd_q <= q_cmd;
						state_q <= S_OUT;
						case (q_cmd.op)
							OP_ARM: begin
								fill_q <= '0;
								drop_q <= '0;
								cap_q <= 1'b1;
							end
							OP_DISARM: cap_q <= 1'b0;
							OP_RECORD: begin
								if (cap_q) begin
									if (full) drop_q <= drop_inc;
									else fill_q <= fill_q + CW'(1);
								end
							end
							OP_STOP: begin
								if (cap_q) begin
									if (summarize && fill_q != '0) begin
										scan_q <= fill_q;
										state_q <= S_RD;
									end else if (full) drop_q <= drop_inc;
									else fill_q <= fill_q + CW'(1);
								end
							end
							OP_READ: state_q <= S_RDW;
							default: ;
						endcase
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (rk == STOP_KIND && ra == cmd_q.addr && rr == cmd_q.res) begin
						if (rs == ALL_ONES) drop_q <= drop_inc;
						state_q <= S_OUT;
					end else if (rk != STOP_KIND || scan_q == CW'(1)) begin
						if (full) drop_q <= drop_inc;
						else fill_q <= fill_q + CW'(1);
						state_q <= S_OUT;
					end else begin
						scan_q <= scan_q - CW'(1);
						state_q <= S_RD;
					end
				end
				S_RDW: state_q <= S_OUT;
				S_OUT: begin
					rsp_valid <= 1'b1;
					rsp.count <= 9'(fill_q);
					rsp.drops <= drop_q;
					if (cmd_q.op == OP_READ && 32'(cmd_q.idx) < 32'(fill_q)) begin
						{rsp.kind, rsp.addr, rsp.size, rsp.res} <= rd_q;
					end else begin
						{rsp.kind, rsp.addr, rsp.size, rsp.res} <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/trace_buffer_with_run_coalescing.sv -----
// ----------------------------------------------------------------------------
// trace_buffer_with_run_coalescing
// Bounded event trace recorder with stop-event run coalescing.
// ----------------------------------------------------------------------------
// Each item gives one result. A coalescing stop scans the tail run of stop
// entries one entry at a time, reading it in S_RD and checking it in S_CHK.
// A two-entry command queue lets the front accept items while the back end
// works.
`timescale 1ns / 1ps
module trace_buffer_with_run_coalescing #(
	parameter int TRACE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	tbrc_cmd_if.sink    in_ch,
	tbrc_rsp_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tbrc_pkg::*;
	logic summ_q;
	logic q_valid, q_pop;
	cmd_t q_cmd;
	rsp_t rsp;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SUMMARIZE) ? {31'd0, summ_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) summ_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == REG_SUMMARIZE) summ_q <= pwdata[0];
	end

	tbrc_front u_front (.clk, .arst_n, .in_ch, .q_valid, .q_cmd, .q_pop);

	tbrc_back #(.TRACE_DEPTH(TRACE_DEPTH)) u_back (
		.clk, .arst_n, .summarize(summ_q), .q_valid, .q_cmd, .q_pop,
		.rsp_valid(out_ch.valid), .rsp, .rsp_ready(out_ch.ready));

	assign out_ch.entry_kind = rsp.kind;
	assign out_ch.entry_address = rsp.addr;
	assign out_ch.entry_size = rsp.size;
	assign out_ch.entry_result = rsp.res;
	assign out_ch.entry_count = rsp.count;
	assign out_ch.drop_total = rsp.drops;
endmodule

// ----- rtl/tbrc_checker.sv -----
// ----------------------------------------------------------------------------
// tbrc_checker
// Port-level checks of the trace buffer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trace_buffer_with_run_coalescing_defines.svh"
module tbrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [8:0] entry_count,
	input logic [31:0] entry_kind,
	input logic [31:0] drop_total,
	input logic       pready
);
	`TB_ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready)
	`TB_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, $stable(drop_total))
	`TB_ASSERT_IMPL(a_cnt, clk, arst_n, out_valid, entry_count <= 9'd256)
	`TB_ASSERT_IMPL(a_zero, clk, arst_n, out_valid && entry_count == 9'd0,
		entry_kind == 32'd0)
endmodule

bind trace_buffer_with_run_coalescing tbrc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.entry_count(out_ch.entry_count), .entry_kind(out_ch.entry_kind),
	.drop_total(out_ch.drop_total), .pready(pready));
